@@ hw/rtl/otf_pkg.sv @@
// Shared types and constants for the Otsu threshold finder.
`timescale 1ns / 1ps

package otf_pkg;

    // Pixel field width and the limb width of the wide multiplier
    localparam int GRAY_W = 8;
    localparam int LIMB_W = 32;

    // Top-level flow: collect pixels, let the last write land, sweep, hand off
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_SWEEP,
        ST_HOLD
    } t_top_state;

    // Level sweep sequencer
    typedef enum logic [3:0] {
        SW_IDLE,
        SW_READ,
        SW_LOAD,
        SW_MSTART,
        SW_MWAIT,
        SW_DIFF,
        SW_CMP,
        SW_ADV,
        SW_FINISH
    } t_sweep_state;

    // Products that the sweep takes from the shared multiplier, in order
    typedef enum logic [2:0] {
        MOP_A,
        MOP_B,
        MOP_DEN,
        MOP_NUM,
        MOP_LHS,
        MOP_RHS
    } t_mul_op;

endpackage

@@ hw/rtl/otf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module otf_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/otf_hist.sv @@
// Level histogram in RAM with read-modify-write update, plus pixel count and level sum.
`timescale 1ns / 1ps

module otf_hist
    import otf_pkg::*;
#(
    parameter int COUNT_BITS = 22,
    parameter int DEPTH      = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_pix_vld,
    input  logic [GRAY_W-1:0]                      i_level,
    input  logic                                   i_clear,
    input  logic                                   i_sw_rd_en,
    input  logic [$clog2(DEPTH)-1:0]               i_sw_addr,
    output logic [COUNT_BITS-1:0]                  o_sw_data,
    output logic [COUNT_BITS-1:0]                  o_total,
    output logic [COUNT_BITS+$clog2(DEPTH)-1:0]    o_sum
);

    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = COUNT_BITS + AW;

    logic [AW-1:0]         w_lvl;
    logic                  w_count_en;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic [COUNT_BITS-1:0] w_old;
    logic [COUNT_BITS-1:0] w_new;

    logic                  r_s1_vld;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_fwd_vld;
    logic [AW-1:0]         r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [DEPTH-1:0]      r_valid;
    logic [COUNT_BITS-1:0] r_total;
    logic [SUM_W-1:0]      r_sum;

    // Saturate the level to the top histogram bin
    assign w_lvl = (i_level > GRAY_W'(DEPTH - 1)) ? AW'(DEPTH - 1) : AW'(i_level);

    // Drop pixels once the count is full
    assign w_count_en = (r_total != {COUNT_BITS{1'b1}});

    // Share the read port between the update path and the sweep
    assign w_rd_en   = i_pix_vld | i_sw_rd_en;
    assign w_rd_addr = i_sw_rd_en ? i_sw_addr : w_lvl;

    otf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (w_new),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Take the bin from the last write when it hits the same entry
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_rd_addr)) begin
            w_old = r_fwd_data;
        end else if (r_valid[r_rd_addr]) begin
            w_old = w_rd_data;
        end else begin
            w_old = '0;
        end
    end

    assign w_new     = w_old + COUNT_BITS'(1);
    assign o_sw_data = r_valid[r_rd_addr] ? w_rd_data : '0;
    assign o_total   = r_total;
    assign o_sum     = r_sum;

    // Control: update stage, forwarding, valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_valid   <= '0;
            r_total   <= '0;
            r_sum     <= '0;
        end else begin
            r_s1_vld  <= i_pix_vld & w_count_en;
            r_fwd_vld <= r_s1_vld;
            if (i_clear) begin
                r_valid <= '0;
                r_total <= '0;
                r_sum   <= '0;
            end else begin
                if (r_s1_vld) begin
                    r_valid[r_rd_addr] <= 1'b1;
                end
                if (i_pix_vld && w_count_en) begin
                    r_total <= r_total + COUNT_BITS'(1);
                    r_sum   <= r_sum + SUM_W'(w_lvl);
                end
            end
        end
    end

    // Payload: address in flight and the forwarded bin
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_addr <= w_rd_addr;
        end
        if (r_s1_vld) begin
            r_fwd_addr <= r_rd_addr;
            r_fwd_data <= w_new;
        end
    end

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == {COUNT_BITS{1'b1}}) && !i_clear |=> r_total == {COUNT_BITS{1'b1}})
        else $error("pixel count left saturation without a clear");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_valid == '0) && (r_total == '0) && (r_sum == '0))
        else $error("histogram not empty after clear");

endmodule

@@ hw/rtl/otf_mul.sv @@
// Wide unsigned multiplier built from one 32x32 multiplier, one limb pair per cycle.
`timescale 1ns / 1ps

module otf_mul
    import otf_pkg::*;
#(
    parameter int XW = 104,
    parameter int YW = 52
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [XW-1:0]                                i_x,
    input  logic [YW-1:0]                                i_y,
    input  logic [(((XW+LIMB_W-1)/LIMB_W) > 1 ?
                   $clog2((XW+LIMB_W-1)/LIMB_W) : 1)-1:0] i_x_last,
    input  logic [(((YW+LIMB_W-1)/LIMB_W) > 1 ?
                   $clog2((YW+LIMB_W-1)/LIMB_W) : 1)-1:0] i_y_last,
    output logic                                         o_done,
    output logic [(((XW+LIMB_W-1)/LIMB_W) +
                   ((YW+LIMB_W-1)/LIMB_W))*LIMB_W-1:0]    o_prod
);

    localparam int NXL   = (XW + LIMB_W - 1) / LIMB_W;
    localparam int NYL   = (YW + LIMB_W - 1) / LIMB_W;
    localparam int LXW   = (NXL > 1) ? $clog2(NXL) : 1;
    localparam int LYW   = (NYL > 1) ? $clog2(NYL) : 1;
    localparam int XPW   = NXL * LIMB_W;
    localparam int YPW   = NYL * LIMB_W;
    localparam int PAW   = (NXL + NYL) * LIMB_W;
    localparam int POS_W = $clog2(NXL + NYL);

    logic [XPW-1:0]      w_x_pad;
    logic [YPW-1:0]      w_y_pad;
    logic [LIMB_W-1:0]   w_xl;
    logic [LIMB_W-1:0]   w_yl;

    logic                r_busy;
    logic                r_issue;
    logic                r_pp_vld;
    logic [LXW-1:0]      r_ix;
    logic [LYW-1:0]      r_iy;
    logic [2*LIMB_W-1:0] r_pp;
    logic [POS_W-1:0]    r_pos;
    logic [PAW-1:0]      r_acc;

    assign w_x_pad = XPW'(i_x);
    assign w_y_pad = YPW'(i_y);
    assign w_xl    = w_x_pad[r_ix*LIMB_W +: LIMB_W];
    assign w_yl    = w_y_pad[r_iy*LIMB_W +: LIMB_W];

    // Done once every partial product has been issued and accumulated
    assign o_done = r_busy & ~r_issue & ~r_pp_vld;
    assign o_prod = r_acc;

    // Control: limb counters, y limb innermost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_issue  <= 1'b0;
            r_pp_vld <= 1'b0;
            r_ix     <= '0;
            r_iy     <= '0;
        end else if (i_start) begin
            r_busy   <= 1'b1;
            r_issue  <= 1'b1;
            r_pp_vld <= 1'b0;
            r_ix     <= '0;
            r_iy     <= '0;
        end else begin
            r_pp_vld <= r_issue;
            if (o_done) begin
                r_busy <= 1'b0;
            end
            if (r_issue) begin
                if (r_iy == i_y_last) begin
                    r_iy <= '0;
                    if (r_ix == i_x_last) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_ix <= r_ix + LXW'(1);
                    end
                end else begin
                    r_iy <= r_iy + LYW'(1);
                end
            end
        end
    end

    // Datapath: register each partial product, then add it in at its limb offset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + (PAW'(r_pp) << (r_pos * LIMB_W));
        end
        if (r_issue) begin
            r_pp  <= w_xl * w_yl;
            r_pos <= POS_W'(r_ix) + POS_W'(r_iy);
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

@@ hw/rtl/otf_sweep.sv @@
// Level sweep: running class sums and exact cross-multiplied variance comparison.
`timescale 1ns / 1ps

module otf_sweep
    import otf_pkg::*;
#(
    parameter int COUNT_BITS = 22,
    parameter int DEPTH      = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [COUNT_BITS-1:0]               i_total,
    input  logic [COUNT_BITS+$clog2(DEPTH)-1:0] i_sum,
    input  logic [COUNT_BITS-1:0]               i_hist_data,
    output logic                                o_rd_en,
    output logic [$clog2(DEPTH)-1:0]            o_rd_addr,
    output logic                                o_done,
    output logic [$clog2(DEPTH)-1:0]            o_thr
);

    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = COUNT_BITS + AW;       // class level sums
    localparam int A_W   = 2 * COUNT_BITS + AW;   // sumB*T, q1*S and their difference
    localparam int D_W   = 2 * COUNT_BITS;        // q1*q2
    localparam int N_W   = 2 * A_W;               // squared difference
    localparam int L_W   = N_W + D_W;             // cross products
    localparam int MX    = N_W;
    localparam int MY    = A_W;
    localparam int NXL   = (MX + LIMB_W - 1) / LIMB_W;
    localparam int NYL   = (MY + LIMB_W - 1) / LIMB_W;
    localparam int LXW   = (NXL > 1) ? $clog2(NXL) : 1;
    localparam int LYW   = (NYL > 1) ? $clog2(NYL) : 1;
    localparam int PAW   = (NXL + NYL) * LIMB_W;

    // Last limb index of each operand
    localparam int XL_SUM = (SUM_W + LIMB_W - 1) / LIMB_W - 1;
    localparam int XL_CNT = (COUNT_BITS + LIMB_W - 1) / LIMB_W - 1;
    localparam int XL_A   = (A_W + LIMB_W - 1) / LIMB_W - 1;
    localparam int XL_N   = (N_W + LIMB_W - 1) / LIMB_W - 1;
    localparam int XL_D   = (D_W + LIMB_W - 1) / LIMB_W - 1;

    t_sweep_state r_state;
    t_sweep_state n_state;
    t_mul_op      r_op;

    logic [AW-1:0]         r_lvl;
    logic [COUNT_BITS-1:0] r_q1;
    logic [COUNT_BITS-1:0] r_q2;
    logic [SUM_W-1:0]      r_sumb;
    logic [A_W-1:0]        r_a;
    logic [A_W-1:0]        r_b;
    logic [A_W-1:0]        r_d;
    logic [D_W-1:0]        r_den;
    logic [N_W-1:0]        r_num;
    logic [L_W-1:0]        r_lhs;
    logic [N_W-1:0]        r_best_num;
    logic [D_W-1:0]        r_best_den;
    logic [AW-1:0]         r_thr;

    logic [COUNT_BITS-1:0] w_q1;
    logic [COUNT_BITS-1:0] w_q2;
    logic                  w_mul_start;
    logic                  w_mul_done;
    logic [MX-1:0]         w_mx;
    logic [MY-1:0]         w_my;
    logic [LXW-1:0]        w_x_last;
    logic [LYW-1:0]        w_y_last;
    logic [PAW-1:0]        w_prod;

    // Class counts after adding this level
    assign w_q1 = r_q1 + i_hist_data;
    assign w_q2 = i_total - w_q1;

    // Operands of the current product
    always_comb begin
        case (r_op)
            MOP_A: begin
                w_mx     = MX'(r_sumb);
                w_my     = MY'(i_total);
                w_x_last = LXW'(XL_SUM);
                w_y_last = LYW'(XL_CNT);
            end
            MOP_B: begin
                w_mx     = MX'(r_q1);
                w_my     = MY'(i_sum);
                w_x_last = LXW'(XL_CNT);
                w_y_last = LYW'(XL_SUM);
            end
            MOP_DEN: begin
                w_mx     = MX'(r_q1);
                w_my     = MY'(r_q2);
                w_x_last = LXW'(XL_CNT);
                w_y_last = LYW'(XL_CNT);
            end
            MOP_NUM: begin
                w_mx     = MX'(r_d);
                w_my     = r_d;
                w_x_last = LXW'(XL_A);
                w_y_last = LYW'(XL_A);
            end
            MOP_LHS: begin
                w_mx     = r_num;
                w_my     = MY'(r_best_den);
                w_x_last = LXW'(XL_N);
                w_y_last = LYW'(XL_D);
            end
            MOP_RHS: begin
                w_mx     = r_best_num;
                w_my     = MY'(r_den);
                w_x_last = LXW'(XL_N);
                w_y_last = LYW'(XL_D);
            end
            default: begin
                w_mx     = '0;
                w_my     = '0;
                w_x_last = '0;
                w_y_last = '0;
            end
        endcase
    end

    otf_mul #(
        .XW (MX),
        .YW (MY)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_x      (w_mx),
        .i_y      (w_my),
        .i_x_last (w_x_last),
        .i_y_last (w_y_last),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SW_IDLE: begin
                if (i_start) begin
                    n_state = SW_READ;
                end
            end
            SW_READ: n_state = SW_LOAD;
            SW_LOAD: begin
                if (w_q1 == '0) begin
                    n_state = SW_ADV;
                end else if (w_q2 == '0) begin
                    n_state = SW_FINISH;
                end else begin
                    n_state = SW_MSTART;
                end
            end
            SW_MSTART: n_state = SW_MWAIT;
            SW_MWAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        MOP_B:   n_state = SW_DIFF;
                        MOP_RHS: n_state = SW_CMP;
                        default: n_state = SW_MSTART;
                    endcase
                end
            end
            SW_DIFF: n_state = SW_MSTART;
            SW_CMP:  n_state = SW_ADV;
            SW_ADV: begin
                if (r_lvl == AW'(DEPTH - 1)) begin
                    n_state = SW_FINISH;
                end else begin
                    n_state = SW_READ;
                end
            end
            SW_FINISH: n_state = SW_IDLE;
            default:   n_state = SW_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rd_en     = 1'b0;
        w_mul_start = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            SW_READ:   o_rd_en     = 1'b1;
            SW_MSTART: w_mul_start = 1'b1;
            SW_FINISH: o_done      = 1'b1;
            default: begin
                o_rd_en     = 1'b0;
                w_mul_start = 1'b0;
                o_done      = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = r_lvl;
    assign o_thr     = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            SW_IDLE: begin
                if (i_start) begin
                    r_lvl      <= '0;
                    r_q1       <= '0;
                    r_sumb     <= '0;
                    r_best_num <= '0;
                    r_best_den <= D_W'(1);
                    r_thr      <= '0;
                end
            end
            SW_LOAD: begin
                r_q1   <= w_q1;
                r_q2   <= w_q2;
                r_sumb <= r_sumb + SUM_W'(r_lvl) * SUM_W'(i_hist_data);
                r_op   <= MOP_A;
            end
            SW_MWAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        MOP_A: begin
                            r_a  <= w_prod[A_W-1:0];
                            r_op <= MOP_B;
                        end
                        MOP_B: begin
                            r_b  <= w_prod[A_W-1:0];
                            r_op <= MOP_DEN;
                        end
                        MOP_DEN: begin
                            r_den <= w_prod[D_W-1:0];
                            r_op  <= MOP_NUM;
                        end
                        MOP_NUM: begin
                            r_num <= w_prod[N_W-1:0];
                            r_op  <= MOP_LHS;
                        end
                        MOP_LHS: begin
                            r_lhs <= w_prod[L_W-1:0];
                            r_op  <= MOP_RHS;
                        end
                        default: r_op <= r_op;
                    endcase
                end
            end
            SW_DIFF: begin
                r_d <= (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
            end
            SW_CMP: begin
                // Keep the first level that strictly beats the best so far
                if (r_lhs > w_prod[L_W-1:0]) begin
                    r_best_num <= r_num;
                    r_best_den <= r_den;
                    r_thr      <= r_lvl;
                end
            end
            SW_ADV: begin
                r_lvl <= r_lvl + AW'(1);
            end
            default: r_lvl <= r_lvl;
        endcase
    end

    a_best_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SW_CMP) |-> (r_best_den != '0) && (r_den != '0))
        else $error("zero denominator in variance comparison");

    a_classes_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SW_MSTART) |-> (r_q1 != '0) && (r_q2 != '0))
        else $error("product started for a level with an empty class");

endmodule

@@ hw/rtl/otsu_threshold_finder_unit.sv @@
// Top level of the Otsu threshold finder: stream ports, flow control and result register.
//
//   Channel  Dir  Handshake                       Payload
//   s_axis   in   i_s_axis_tvalid/o_s_axis_tready tdata[7:0] gray_level, tlast last_pixel
//   m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata[7:0] threshold_level
//
// Pixels are taken one per cycle; each updates a RAM histogram bin by read-modify-write.
// After the last pixel: a drain state, then the sweep, which skips the products for a level
// with an empty background and takes six products for each other level; the sweep is paced
// by the shared 32x32 multiplier.
// Reset and each result clear the histogram at once through per-bin valid bits.
// Pixels are refused from the last pixel until the result is loaded into the output register.
`timescale 1ns / 1ps

module otsu_threshold_finder_unit
    import otf_pkg::*;
#(
    parameter int MAX_LEVEL  = 255,
    parameter int COUNT_BITS = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [GRAY_W-1:0] i_s_axis_tdata,   // [7:0] gray_level
    input  logic              i_s_axis_tlast,   // last_pixel
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [GRAY_W-1:0] o_m_axis_tdata    // [7:0] threshold_level
);

    localparam int TOP_LEVEL = (MAX_LEVEL < 255) ? MAX_LEVEL : 255;
    localparam int DEPTH     = TOP_LEVEL + 1;
    localparam int AW        = $clog2(DEPTH);
    localparam int SUM_W     = COUNT_BITS + AW;

    t_top_state r_state;
    t_top_state n_state;

    logic                  r_out_vld;
    logic [GRAY_W-1:0]     r_out_data;

    logic                  w_accept;
    logic                  w_sw_start;
    logic                  w_sw_done;
    logic                  w_load;
    logic                  w_sw_rd_en;
    logic [AW-1:0]         w_sw_addr;
    logic [COUNT_BITS-1:0] w_sw_data;
    logic [COUNT_BITS-1:0] w_total;
    logic [SUM_W-1:0]      w_sum;
    logic [AW-1:0]         w_thr;

    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;

    otf_hist #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH      (DEPTH)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_vld  (w_accept),
        .i_level    (i_s_axis_tdata),
        .i_clear    (w_load),
        .i_sw_rd_en (w_sw_rd_en),
        .i_sw_addr  (w_sw_addr),
        .o_sw_data  (w_sw_data),
        .o_total    (w_total),
        .o_sum      (w_sum)
    );

    otf_sweep #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH      (DEPTH)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sw_start),
        .i_total     (w_total),
        .i_sum       (w_sum),
        .i_hist_data (w_sw_data),
        .o_rd_en     (w_sw_rd_en),
        .o_rd_addr   (w_sw_addr),
        .o_done      (w_sw_done),
        .o_thr       (w_thr)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCUM: begin
                if (w_accept && i_s_axis_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (w_sw_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_sw_start      = 1'b0;
        w_load          = 1'b0;
        case (r_state)
            ST_ACCUM: o_s_axis_tready = 1'b1;
            ST_DRAIN: w_sw_start      = 1'b1;
            ST_HOLD:  w_load          = ~r_out_vld | i_m_axis_tready;
            default: begin
                o_s_axis_tready = 1'b0;
                w_sw_start      = 1'b0;
                w_load          = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCUM;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= GRAY_W'(w_thr);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    a_done_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sw_done |-> (r_state == ST_SWEEP))
        else $error("sweep finished outside the sweep phase");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_axis_tvalid && !w_sw_rd_en)
        else $error("result load did not present a result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Otsu threshold finder unit.
`timescale 1ns / 1ps

// Track pixels per image, predict each threshold and check it on arrival
class threshold_tracker;
    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 22;

    bit [COUNT_BITS-1:0] level_counts[LEVELS];
    bit [COUNT_BITS-1:0] pixel_count;
    bit [29:0]           level_sum;
    bit [7:0]            expected_thresholds[$];
    int                  errors;
    int                  checked;

    function new();
        errors  = 0;
        checked = 0;
        clear_image();
    endfunction

    function void clear_image();
        foreach (level_counts[i]) level_counts[i] = '0;
        pixel_count = '0;
        level_sum   = '0;
    endfunction

    // Sweep levels upward, keep the first level with the largest exact variance ratio
    function bit [7:0] otsu_sweep();
        bit [255:0] best_num, best_den, prod_a, prod_b, diff, num, den, lhs, rhs;
        bit [63:0]  q1, q2, sum_b;
        bit [7:0]   thr;
        best_num = '0;
        best_den = 256'd1;
        q1       = '0;
        sum_b    = '0;
        thr      = '0;
        for (int i = 0; i < LEVELS; i++) begin
            q1 += 64'(level_counts[i]);
            if (q1 == 0) continue;
            q2 = 64'(pixel_count) - q1;
            if (q2 == 0) break;
            sum_b += 64'(i) * 64'(level_counts[i]);
            prod_a = 256'(sum_b) * 256'(pixel_count);
            prod_b = 256'(q1) * 256'(level_sum);
            diff   = (prod_a >= prod_b) ? prod_a - prod_b : prod_b - prod_a;
            num    = diff * diff;
            den    = 256'(q1 * q2);
            lhs    = num * best_den;
            rhs    = best_num * den;
            if (lhs > rhs) begin
                best_num = num;
                best_den = den;
                thr      = i[7:0];
            end
        end
        return thr;
    endfunction

    // Count one accepted pixel; on the last one queue the threshold and start over
    function void note_pixel(bit [7:0] level, bit last);
        if (pixel_count != {COUNT_BITS{1'b1}}) begin
            level_counts[level]++;
            pixel_count++;
            level_sum += 30'(level);
        end
        if (last) begin
            expected_thresholds.push_back(otsu_sweep());
            clear_image();
        end
    endfunction

    // Compare one output transaction with the oldest queued threshold
    function void check_threshold(bit [7:0] got);
        bit [7:0] want;
        checked++;
        if (expected_thresholds.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: threshold %0d with no image pending", got);
            return;
        end
        want = expected_thresholds.pop_front();
        if (got != want) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: threshold_level expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module tb_top;
    import otf_pkg::*;

    localparam int LIMIT_CYCLES = 25_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [GRAY_W-1:0] s_data = '0;     // [7:0] gray_level
    logic              s_last = 1'b0;   // last_pixel
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [GRAY_W-1:0] m_data;          // [7:0] threshold_level

    threshold_tracker tracker = new();
    bit gaps_on = 1'b1;
    int n_items = 0;
    int n_images = 0;

    otsu_threshold_finder_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one pixel, idling at random first, and hold it until the transaction
    task automatic send_pixel(input logic [7:0] level, input logic last);
        @(negedge clk);
        gaps_on = !(n_items >= 400 && n_items < 650);
        while (gaps_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= level;
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        tracker.note_pixel(level, last);
        n_items++;
        if (last) n_images++;
    endtask

    // Build one image around one or two level clusters
    task automatic send_random_image();
        int kind, npx, c1, c2, spread, level;
        kind = $urandom_range(99);
        npx  = $urandom_range(2, 24);
        c1   = $urandom_range(255);
        c2   = c1;
        if (kind < 55) begin
            spread = $urandom_range(1, 12);
        end else if (kind < 75) begin
            c2     = $urandom_range(255);
            spread = $urandom_range(0, 8);
        end else if (kind < 90) begin
            c1     = 0;
            c2     = 0;
            spread = 255;
            npx    = $urandom_range(1, 40);
        end else begin
            spread = 0;
            npx    = $urandom_range(1, 6);
        end
        for (int k = 0; k < npx; k++) begin
            level = ($urandom_range(1) ? c1 : c2) + $urandom_range(spread);
            if (level > 255) level = 255;
            send_pixel(level[7:0], k == npx - 1);
        end
    endtask

    // Drive images: directed corners first, then random ones
    initial begin
        byte unsigned dir_levels[21] = '{
            0,
            255,
            0, 255,
            128, 128, 128,
            1, 2, 4, 8, 16, 32, 64, 128, 254, 255,
            10, 200, 200, 30
        };
        int dir_lens[6] = '{1, 1, 2, 3, 10, 4};
        int idx;
        idx = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        foreach (dir_lens[j]) begin
            for (int k = 0; k < dir_lens[j]; k++) begin
                send_pixel(dir_levels[idx], k == dir_lens[j] - 1);
                idx++;
            end
        end
        while (n_items < 1100 || n_images < 40) send_random_image();
        @(negedge clk);
        s_valid <= 1'b0;
        while (tracker.expected_thresholds.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Drive output ready: random stalls plus one long hold-off to back up the input
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && tracker.checked >= 10) begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(gaps_on && $urandom_range(99) < 11);
            end
        end
    end

    // Check each output transaction
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) tracker.check_threshold(m_data);
    end

    // Stop a hung run
    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end
endmodule
